/* rtl/core/pta_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the PID table allocator.
package pta_pkg;

    localparam int ID_COUNT_DEF     = 4096;
    localparam int KERNEL_FIRST_DEF = 256;
    localparam int USER_FIRST_ID    = 1;

    localparam int WORD_W   = 64;              // used-map bits per memory word
    localparam int POS_W    = $clog2(WORD_W);  // bit position inside a word
    localparam int REQ_ID_W = 16;              // target_id width
    localparam int TASK_W   = 12;              // caller, parent and result ID width

    typedef enum logic [1:0] {
        OP_ALLOC_USER = 2'd0,
        OP_ALLOC_KERN = 2'd1,
        OP_FREE       = 2'd2,
        OP_LOOKUP     = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RANGE     = 3'd1,
        ST_UNMAPPED  = 3'd2,
        ST_DENIED    = 3'd3,
        ST_EXHAUSTED = 3'd4
    } t_status;

    typedef struct packed {
        t_opcode               opcode;
        logic [REQ_ID_W-1:0]   target_id;
        logic [TASK_W-1:0]     parent_id;
        logic                  check_owner;
        logic [TASK_W-1:0]     caller_id;
    } t_req;

    typedef struct packed {
        logic [TASK_W-1:0] result_id;
        t_status           status;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture item, issue first reads
        logic clr_step;  // clear one used-map word
        logic check_en;  // resolve free / lookup and answer
        logic scan_en;   // examine one used-map word of an allocation
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;  // clearing pass is at its last word
        logic alloc;     // item on the request port is an allocation
        logic scan_end;  // free bit found or last word examined
    } t_stat;

    function automatic logic f_is_alloc(input t_opcode op);
        return (op == OP_ALLOC_USER) || (op == OP_ALLOC_KERN);
    endfunction

    // ID that a free or lookup names: target 0 is the current task
    function automatic logic [REQ_ID_W-1:0] f_res_index(input t_req req);
        logic [REQ_ID_W-1:0] idx;
        if (req.target_id == '0) begin
            idx = REQ_ID_W'(req.caller_id);
        end else begin
            idx = req.target_id;
        end
        return idx;
    endfunction

endpackage

/* rtl/core/pta_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing state machine of the PID table allocator.
module pta_ctrl
    import pta_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output logic  o_busy,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_CHECK = 4'b0100,
        S_SCAN  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.alloc ? S_SCAN : S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check_en = 1'b1;
                n_state        = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* rtl/core/pta_dpath.sv */
`timescale 1ns / 1ps
// Used-map and parent memories, first-free search and request resolution.
module pta_dpath
    import pta_pkg::*;
#(
    parameter int ID_COUNT        = ID_COUNT_DEF,
    parameter int KERNEL_FIRST_ID = KERNEL_FIRST_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_req  i_req,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output logic  o_valid,
    output t_rsp  o_rsp
);

    localparam int WORDS     = (ID_COUNT + WORD_W - 1) / WORD_W;
    localparam int WA_W      = $clog2(WORDS);
    localparam int ID_W      = WA_W + POS_W;
    localparam int LAST_BITS = ID_COUNT - (WORDS - 1) * WORD_W;

    localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);
    localparam logic [WA_W-1:0]   LAST_WORD = WA_W'(WORDS - 1);
    localparam logic [WA_W-1:0]   KERN_WORD = WA_W'(KERNEL_FIRST_ID / WORD_W);
    localparam logic [POS_W-1:0]  KERN_POS  = POS_W'(KERNEL_FIRST_ID % WORD_W);
    localparam logic [WA_W-1:0]   USER_WORD = WA_W'(USER_FIRST_ID / WORD_W);
    localparam logic [POS_W-1:0]  USER_POS  = POS_W'(USER_FIRST_ID % WORD_W);
    localparam logic [REQ_ID_W:0] ID_LIMIT  = (REQ_ID_W + 1)'(ID_COUNT);

    // memories
    logic [WORD_W-1:0] r_used_mem   [WORDS];
    logic [TASK_W-1:0] r_parent_mem [ID_COUNT];

    t_req              r_req;
    logic [WORD_W-1:0] r_word;
    logic [WA_W-1:0]   r_word_addr;
    logic [TASK_W-1:0] r_parent;
    logic              r_first;
    logic [WA_W-1:0]   r_clr_addr;
    logic              r_valid;
    t_rsp              r_rsp;

    logic [REQ_ID_W-1:0] in_idx;
    logic [REQ_ID_W-1:0] req_idx;
    logic [ID_W-1:0]     in_id;
    logic [ID_W-1:0]     req_id;
    logic [POS_W-1:0]    req_pos;
    logic                in_alloc;
    logic                rd_en;
    logic [WA_W-1:0]     rd_addr;

    logic [POS_W-1:0]    start_pos;
    logic [WORD_W-1:0]   avail;
    logic [WORD_W-1:0]   low1;
    logic [POS_W-1:0]    hit_pos;
    logic                hit;
    logic                scan_last;
    logic                scan_end;
    logic [ID_W-1:0]     alloc_id;
    logic [REQ_ID_W:0]   alloc_id_ext;

    logic                bit_set;
    logic                owner_ok;
    logic                tgt_zero;
    logic                tgt_oor;
    logic                caller_oor;
    t_status             chk_status;
    logic                chk_clear;

    assign in_idx   = f_res_index(i_req);
    assign req_idx  = f_res_index(r_req);
    assign in_id    = in_idx[ID_W-1:0];
    assign req_id   = req_idx[ID_W-1:0];
    assign req_pos  = req_id[POS_W-1:0];
    assign in_alloc = f_is_alloc(i_req.opcode);

    // ---- first-free search over one word ----
    assign start_pos = (r_req.opcode == OP_ALLOC_KERN) ? KERN_POS : USER_POS;
    assign scan_last = (r_word_addr == LAST_WORD);
    assign avail     = ~r_word
                     & (r_first ? ({WORD_W{1'b1}} << start_pos) : {WORD_W{1'b1}})
                     & (scan_last ? LAST_MASK : {WORD_W{1'b1}});
    assign low1      = avail & (~avail + 1'b1);
    assign hit       = |avail;
    assign scan_end  = hit || scan_last;

    always_comb begin
        hit_pos = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (low1[i]) begin
                hit_pos = hit_pos | POS_W'(i);
            end
        end
    end

    assign alloc_id     = {r_word_addr, hit_pos};
    assign alloc_id_ext = (REQ_ID_W + 1)'(alloc_id);

    // ---- free / lookup resolution ----
    assign tgt_zero   = (r_req.target_id == '0);
    assign tgt_oor    = ({1'b0, r_req.target_id} >= ID_LIMIT);
    assign caller_oor = ((REQ_ID_W + 1)'(r_req.caller_id) >= ID_LIMIT);
    assign bit_set    = r_word[req_pos];
    assign owner_ok   = !r_req.check_owner
                      || (r_req.target_id == REQ_ID_W'(r_req.caller_id))
                      || (r_parent == r_req.caller_id);

    always_comb begin
        chk_status = ST_OK;
        chk_clear  = 1'b0;
        if (tgt_zero) begin
            if (r_req.opcode == OP_LOOKUP) begin
                chk_status = ST_OK;
            end else if (caller_oor) begin
                chk_status = ST_RANGE;
            end else begin
                chk_clear = 1'b1;
            end
        end else if (tgt_oor) begin
            chk_status = ST_RANGE;
        end else if (!bit_set) begin
            chk_status = ST_UNMAPPED;
        end else if (!owner_ok) begin
            chk_status = ST_DENIED;
        end else begin
            chk_clear = (r_req.opcode == OP_FREE);
        end
    end

    // ---- read port ----
    always_comb begin
        if (i_cmd.load) begin
            if (in_alloc) begin
                rd_addr = (i_req.opcode == OP_ALLOC_KERN) ? KERN_WORD : USER_WORD;
            end else begin
                rd_addr = in_id[ID_W-1:POS_W];
            end
        end else begin
            rd_addr = r_word_addr + 1'b1;
        end
    end

    assign rd_en = i_cmd.load || (i_cmd.scan_en && !scan_end);

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_word      <= r_used_mem[rd_addr];
            r_word_addr <= rd_addr;
            r_first     <= i_cmd.load;
        end
        if (i_cmd.load) begin
            r_parent <= r_parent_mem[in_id];
            r_req    <= i_req;
        end
    end

    // ---- write port ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_used_mem[r_clr_addr] <= '0;
        end else if (i_cmd.check_en && chk_clear) begin
            r_used_mem[r_word_addr] <= r_word & ~({{(WORD_W-1){1'b0}}, 1'b1} << req_pos);
        end else if (i_cmd.scan_en && hit) begin
            r_used_mem[r_word_addr] <= r_word | low1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_en && hit) begin
            r_parent_mem[alloc_id] <= r_req.parent_id;
        end
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.check_en || (i_cmd.scan_en && scan_end);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check_en) begin
            r_rsp.status    <= chk_status;
            r_rsp.result_id <= (chk_status == ST_OK) ? req_idx[TASK_W-1:0] : '0;
        end else if (i_cmd.scan_en && scan_end) begin
            r_rsp.status    <= hit ? ST_OK : ST_EXHAUSTED;
            r_rsp.result_id <= hit ? alloc_id_ext[TASK_W-1:0] : '0;
        end
    end

    assign o_stat.clr_last = (r_clr_addr == LAST_WORD);
    assign o_stat.alloc    = in_alloc;
    assign o_stat.scan_end = scan_end;
    assign o_valid         = r_valid;
    assign o_rsp           = r_rsp;

endmodule

/* rtl/core/pid_table_allocator.sv */
`timescale 1ns / 1ps
// Top level of the PID table allocator: controller, datapath and checks.
//
//  channel   | ports                  | handshake
//  ----------+------------------------+--------------------------------------
//  request   | start, i_req, busy     | item taken on a clock edge with start=1, busy=0
//  result    | o_valid, o_rsp         | one-cycle strobe, no back-pressure
//
// Operation: free and lookup are resolved in S_CHECK and the result is registered. An allocation
//   examines one 64-bit used-map word per cycle starting at the word that holds its
//   first candidate ID, up to ceil(ID_COUNT/64) words (64 at the default size); the single
//   used-map read port sets this rate.
// Reset: after i_rst_n the used map is cleared one word per cycle, ceil(ID_COUNT/64)
//   words (64 by default), with busy held high.
// Stalls: busy stays high from accept up to the cycle before the result strobe, so a new
//   item may be accepted while the previous result is on o_rsp. The receiver cannot stall.
module pid_table_allocator
    import pta_pkg::*;
#(
    parameter int ID_COUNT        = ID_COUNT_DEF,
    parameter int KERNEL_FIRST_ID = KERNEL_FIRST_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_rsp o_rsp
);

    t_cmd  cmd;
    t_stat stat;

    // sequencing: clear pass, idle, resolve, or scan
    pta_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // memories, search and the result register
    pta_dpath #(
        .ID_COUNT        (ID_COUNT),
        .KERNEL_FIRST_ID (KERNEL_FIRST_ID)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // a result only follows a cycle in which an item was being worked on
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without an item in progress");

    // an accepted item makes the block busy and has no result in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted item did not hold the block busy");

    // every failure reports ID zero
    a_fail_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status != ST_OK)) |-> (o_rsp.result_id == '0))
        else $error("failed item reported a nonzero ID");

    // the controller only issues one datapath command at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.clr_step, cmd.check_en, cmd.scan_en}))
        else $error("conflicting datapath commands");

endmodule
